// ----- hw/rtl/fan_duty_curve_hysteresis_assert.svh -----
// Assertion macros for the fan curve RTL.
`ifndef FAN_DUTY_CURVE_HYSTERESIS_ASSERT_SVH
`define FAN_DUTY_CURVE_HYSTERESIS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FDC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fan curve check failed");

// Next-cycle implication, disabled during reset.
`define FDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fan curve check failed");

`endif

// ----- hw/rtl/fdc_pkg.sv -----
`default_nettype none
package fdc_pkg;

  localparam int unsigned TEMP_W = 8;
  localparam int unsigned RAW_W = 8;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] MAX_EXTRA_GPUS = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_AUTO_ENABLE = 2'd0;
  localparam logic [1:0] REG_PERF_MODE = 2'd1;
  localparam logic [1:0] REG_EXTRA_GPUS = 2'd2;

  typedef struct packed {
    logic       auto_enable;
    logic       perf_curve;
    logic [1:0] extra_gpu_count;
  } cfg_t;

  typedef struct packed {
    logic              write_valid;
    logic [RAW_W-1:0]  duty_raw;
    logic [PCT_W-1:0]  target_percent;
    logic [TEMP_W-1:0] hottest_temp;
  } eval_t;

  // floor(raw*100/255): x/255 == (x + (x>>8) + 1) >> 8 for x below 65535
  function automatic logic [PCT_W-1:0] raw_to_pct(input logic [RAW_W-1:0] raw);
    logic [15:0] prod;
    logic [15:0] sum;
    prod = {8'd0, raw} * 16'd100;
    sum = prod + (prod >> 8) + 16'd1;
    return sum[14:8];
  endfunction

  // floor(pct*255/100) for every step value the curves can produce
  function automatic logic [RAW_W-1:0] pct_to_raw(input logic [PCT_W-1:0] pct);
    logic [RAW_W-1:0] raw;
    unique case (pct)
      7'd10:   raw = 8'd25;
      7'd15:   raw = 8'd38;
      7'd20:   raw = 8'd51;
      7'd25:   raw = 8'd63;
      7'd30:   raw = 8'd76;
      7'd40:   raw = 8'd102;
      7'd50:   raw = 8'd127;
      7'd60:   raw = 8'd153;
      7'd70:   raw = 8'd178;
      7'd80:   raw = 8'd204;
      7'd85:   raw = 8'd216;
      7'd90:   raw = 8'd229;
      7'd100:  raw = 8'd255;
      default: raw = 8'd0;
    endcase
    return raw;
  endfunction

  // Aggressive stepped curve; rising steps first, then falling steps
  function automatic logic [PCT_W-1:0] curve_perf(input logic [TEMP_W-1:0] t,
                                                  input logic [PCT_W-1:0] d);
    logic [PCT_W-1:0] r;
    priority if (t >= 8'd78 && d < 7'd100) r = 7'd100;
    else if (t >= 8'd70 && d < 7'd90) r = 7'd90;
    else if (t >= 8'd60 && d < 7'd80) r = 7'd80;
    else if (t >= 8'd50 && d < 7'd70) r = 7'd70;
    else if (t >= 8'd40 && d < 7'd60) r = 7'd60;
    else if (t >= 8'd30 && d < 7'd50) r = 7'd50;
    else if (t >= 8'd20 && d < 7'd40) r = 7'd40;
    else if (t >= 8'd10 && d < 7'd30) r = 7'd30;
    else if (t <= 8'd15 && d > 7'd30) r = 7'd30;
    else if (t <= 8'd25 && d > 7'd40) r = 7'd40;
    else if (t <= 8'd35 && d > 7'd50) r = 7'd50;
    else if (t <= 8'd45 && d > 7'd60) r = 7'd60;
    else if (t <= 8'd55 && d > 7'd70) r = 7'd70;
    else if (t <= 8'd65 && d > 7'd80) r = 7'd80;
    else if (t <= 8'd75 && d > 7'd90) r = 7'd90;
    else r = 7'd0;
    return r;
  endfunction

  // Quiet stepped curve; its drop to zero reads as no change
  function automatic logic [PCT_W-1:0] curve_quiet(input logic [TEMP_W-1:0] t,
                                                   input logic [PCT_W-1:0] d);
    logic [PCT_W-1:0] r;
    priority if (t >= 8'd80 && d < 7'd50) r = 7'd85;
    else if (t >= 8'd70 && d < 7'd40) r = 7'd40;
    else if (t >= 8'd60 && d < 7'd30) r = 7'd30;
    else if (t >= 8'd55 && d < 7'd25) r = 7'd25;
    else if (t >= 8'd40 && d < 7'd20) r = 7'd20;
    else if (t >= 8'd30 && d < 7'd10) r = 7'd10;
    else if (t <= 8'd15 && d > 7'd0) r = 7'd0;
    else if (t <= 8'd25 && d > 7'd10) r = 7'd10;
    else if (t <= 8'd35 && d > 7'd15) r = 7'd15;
    else if (t <= 8'd45 && d > 7'd20) r = 7'd20;
    else if (t <= 8'd55 && d > 7'd25) r = 7'd25;
    else if (t <= 8'd65 && d > 7'd30) r = 7'd30;
    else if (t <= 8'd75 && d > 7'd50) r = 7'd50;
    else r = 7'd0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fdc_if.sv -----
`default_nettype none
// Sample channel: one sensor tick
interface fdc_in_if;
  import fdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] core_temp;
  logic [TEMP_W-1:0] ctrl_gpu_temp;
  logic [TEMP_W-1:0] gpu_a_temp;
  logic [TEMP_W-1:0] gpu_b_temp;
  logic [RAW_W-1:0]  fan_raw_duty;

  modport source (output valid, core_temp, ctrl_gpu_temp, gpu_a_temp, gpu_b_temp,
                  fan_raw_duty, input ready);
  modport sink (input valid, core_temp, ctrl_gpu_temp, gpu_a_temp, gpu_b_temp,
                fan_raw_duty, output ready);
endinterface

// Result channel: one curve decision per tick
interface fdc_out_if;
  import fdc_pkg::*;
  logic              valid;
  logic              ready;
  logic              write_valid;
  logic [RAW_W-1:0]  duty_raw;
  logic [PCT_W-1:0]  target_percent;
  logic [TEMP_W-1:0] hottest_temp;

  modport source (output valid, write_valid, duty_raw, target_percent, hottest_temp,
                  input ready);
  modport sink (input valid, write_valid, duty_raw, target_percent, hottest_temp,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fdc_cfg_regs.sv -----
`default_nettype none
module fdc_cfg_regs
  import fdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg,
  output logic                    clear
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign idx = paddr[3:2];

  // Any write to a defined register drops the recorded duty
  assign clear = wr_en && (idx == REG_AUTO_ENABLE || idx == REG_PERF_MODE ||
                           idx == REG_EXTRA_GPUS);

  // Hold register values
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_enable <= 1'b1;
      cfg.perf_curve <= 1'b0;
      cfg.extra_gpu_count <= 2'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_AUTO_ENABLE: cfg.auto_enable <= pwdata[0];
        REG_PERF_MODE:   cfg.perf_curve <= pwdata[0];
        REG_EXTRA_GPUS:  cfg.extra_gpu_count <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_AUTO_ENABLE: prdata[0] = cfg.auto_enable;
      REG_PERF_MODE:   prdata[0] = cfg.perf_curve;
      REG_EXTRA_GPUS:  prdata[1:0] = cfg.extra_gpu_count;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fdc_curve.sv -----
`default_nettype none
module fdc_curve
  import fdc_pkg::*;
(
  input  wire cfg_t               cfg,
  input  wire logic [PCT_W-1:0]  last_pct,
  input  wire logic [TEMP_W-1:0] core_temp,
  input  wire logic [TEMP_W-1:0] ctrl_gpu_temp,
  input  wire logic [TEMP_W-1:0] gpu_a_temp,
  input  wire logic [TEMP_W-1:0] gpu_b_temp,
  input  wire logic [RAW_W-1:0]  fan_raw_duty,
  output eval_t                   eval
);

  logic [1:0]        count;
  logic [TEMP_W-1:0] hot_base;
  logic [TEMP_W-1:0] hot_a;
  logic [TEMP_W-1:0] hot;
  logic [PCT_W-1:0]  duty_pct;
  logic [PCT_W-1:0]  target;
  logic              do_write;

  // Saturate the extra sensor count
  assign count = (cfg.extra_gpu_count > MAX_EXTRA_GPUS) ? MAX_EXTRA_GPUS
                                                        : cfg.extra_gpu_count;

  // Hottest enabled reading
  assign hot_base = (core_temp > ctrl_gpu_temp) ? core_temp : ctrl_gpu_temp;
  assign hot_a = (count >= 2'd1 && gpu_a_temp > hot_base) ? gpu_a_temp : hot_base;
  assign hot = (count >= 2'd2 && gpu_b_temp > hot_a) ? gpu_b_temp : hot_a;

  // Current duty in percent, then the curve step
  assign duty_pct = raw_to_pct(fan_raw_duty);
  assign target = cfg.perf_curve ? curve_perf(hot, duty_pct)
                                 : curve_quiet(hot, duty_pct);

  // Write only on a real change while auto mode is on
  assign do_write = cfg.auto_enable && (target != '0) && (target != last_pct);

  assign eval.write_valid = do_write;
  assign eval.duty_raw = do_write ? pct_to_raw(target) : '0;
  assign eval.target_percent = target;
  assign eval.hottest_temp = hot;

endmodule
`default_nettype wire

// ----- hw/rtl/fan_duty_curve_hysteresis.sv -----
// Path: a sample transfer is captured in the input register, then passes through
// compare and lookup logic into the result register; a busy result stalls it.
// Throughput: one sample per cycle while the result sink is ready, set by the
// combinational curve pass and the one-deep recorded duty register that each result updates in order.
// Reset: synchronous, active high; clears valids and recorded duty, auto mode on.
`default_nettype none
module fan_duty_curve_hysteresis
  import fdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  fdc_in_if.sink                  sample,
  fdc_out_if.source               result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t              cfg;
  logic              cfg_clear;
  eval_t             eval;
  logic              s1_valid;
  logic              s1_advance;
  logic [TEMP_W-1:0] s1_cpu;
  logic [TEMP_W-1:0] s1_cgpu;
  logic [TEMP_W-1:0] s1_ga;
  logic [TEMP_W-1:0] s1_gb;
  logic [RAW_W-1:0]  s1_raw;
  logic [PCT_W-1:0]  last_pct;
  logic              out_valid;
  eval_t             out_data;

  fdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (cfg_clear)
  );

  fdc_curve u_curve (
    .cfg           (cfg),
    .last_pct      (last_pct),
    .core_temp     (s1_cpu),
    .ctrl_gpu_temp (s1_cgpu),
    .gpu_a_temp    (s1_ga),
    .gpu_b_temp    (s1_gb),
    .fan_raw_duty  (s1_raw),
    .eval          (eval)
  );

  // Advance when the result register is free or being drained
  assign s1_advance = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
    if (sample.ready && sample.valid) begin
      s1_cpu <= sample.core_temp;
      s1_cgpu <= sample.ctrl_gpu_temp;
      s1_ga <= sample.gpu_a_temp;
      s1_gb <= sample.gpu_b_temp;
      s1_raw <= sample.fan_raw_duty;
    end
  end

  // Result register and recorded duty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_pct <= '0;
    end else begin
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_clear) begin
        last_pct <= '0;
      end else if (s1_advance && eval.write_valid) begin
        last_pct <= eval.target_percent;
      end
    end
    if (s1_advance) begin
      out_data <= eval;
    end
  end

  assign result.valid = out_valid;
  assign result.write_valid = out_data.write_valid;
  assign result.duty_raw = out_data.duty_raw;
  assign result.target_percent = out_data.target_percent;
  assign result.hottest_temp = out_data.hottest_temp;

`include "fan_duty_curve_hysteresis_assert.svh"

  `FDC_ASSERT_SAME(a_no_write_zero_raw, clk, rst, out_valid && !out_data.write_valid,
    out_data.duty_raw == '0)
  `FDC_ASSERT_SAME(a_write_nonzero, clk, rst, out_valid && out_data.write_valid,
    out_data.target_percent != '0 && out_data.duty_raw != '0)
  `FDC_ASSERT_NEXT(a_stalled_item_kept, clk, rst, s1_valid && !s1_advance, s1_valid)

endmodule
`default_nettype wire
